>>> rtl/core/grouped_min_max_sum_count_macros.svh
// ---------------------------------------------------------------------------
// grouped_min_max_sum_count assertion macros
// Shared concurrent assertion shorthands for the group-by block checkers.
// ---------------------------------------------------------------------------
`ifndef GROUPED_MIN_MAX_SUM_COUNT_MACROS_SVH
`define GROUPED_MIN_MAX_SUM_COUNT_MACROS_SVH

// Generic property check, disabled while reset is asserted.
`define GMMSC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same-cycle implication check.
`define GMMSC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  `GMMSC_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

>>> rtl/core/gmmsc_pkg.sv
// ---------------------------------------------------------------------------
// gmmsc_pkg
// Types and constants shared by the group-by aggregation block.
// ---------------------------------------------------------------------------
package gmmsc_pkg;

  localparam int unsigned TableDepthDefault = 64;

  localparam int unsigned KeyW     = 16;
  localparam int unsigned ScoreW   = 32;
  localparam int unsigned SumW     = 64;
  localparam int unsigned CountW   = 32;
  localparam int unsigned InDataW  = 48;   // key + score
  localparam int unsigned OutDataW = 176;  // key + min + max + total + count
  localparam int unsigned OutUserW = 2;    // table_empty, dropped_flag

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [0:0] {
    OpRecord = 1'b0,
    OpFlush  = 1'b1
  } opcode_e;

  typedef enum logic [0:0] {
    StIdle  = 1'b0,
    StFlush = 1'b1
  } state_e;

  // One table slot.
  typedef struct packed {
    logic                     valid;
    logic [KeyW-1:0]          key;
    logic signed [ScoreW-1:0] min_v;
    logic signed [ScoreW-1:0] max_v;
    logic signed [SumW-1:0]   sum;
    logic [CountW-1:0]        count;
  } entry_t;

  // Broadcast control to every cell.
  typedef struct packed {
    logic rec_en;    // record word this cycle
    logic ins_en;    // record opens a new slot
    logic shift_dn;  // flush: move toward cell 0
  } cell_ctl_t;

  // Per-cell compare status.
  typedef struct packed {
    logic lt;   // valid and key below the incoming key
    logic eq;   // valid and key matches
    logic sat;  // match with saturated count
  } cell_stat_t;

endpackage

>>> rtl/core/gmmsc_cell.sv
// ---------------------------------------------------------------------------
// gmmsc_cell
// One slot of the sorted chain: compare, update, insert or shift.
// ---------------------------------------------------------------------------
module gmmsc_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gmmsc_pkg::cell_ctl_t             ctl_i,
  input  logic [gmmsc_pkg::KeyW-1:0]       key_i,
  input  logic signed [gmmsc_pkg::ScoreW-1:0] score_i,
  input  logic                             prev_lt_i,
  input  gmmsc_pkg::entry_t                prev_entry_i,
  input  gmmsc_pkg::entry_t                next_entry_i,
  output gmmsc_pkg::entry_t                entry_o,
  output gmmsc_pkg::cell_stat_t            stat_o
);
  import gmmsc_pkg::*;

  entry_t                 entry_q, entry_d;
  logic signed [SumW-1:0] score_ext;

  assign score_ext = SumW'(score_i);

  assign stat_o.lt  = entry_q.valid && (entry_q.key < key_i);
  assign stat_o.eq  = entry_q.valid && (entry_q.key == key_i);
  assign stat_o.sat = stat_o.eq && (entry_q.count == CountMax);

  always_comb begin
    entry_d = entry_q;
    priority if (ctl_i.shift_dn) begin
      entry_d = next_entry_i;
    end else if (ctl_i.rec_en && stat_o.eq && !stat_o.sat) begin
      if (score_i < entry_q.min_v) entry_d.min_v = score_i;
      if (score_i > entry_q.max_v) entry_d.max_v = score_i;
      entry_d.sum   = entry_q.sum + score_ext;
      entry_d.count = entry_q.count + CountW'(1);
    end else if (ctl_i.ins_en && !stat_o.lt) begin
      if (prev_lt_i) begin
        // insertion point
        entry_d.valid = 1'b1;
        entry_d.key   = key_i;
        entry_d.min_v = score_i;
        entry_d.max_v = score_i;
        entry_d.sum   = score_ext;
        entry_d.count = CountW'(1);
      end else begin
        entry_d = prev_entry_i;  // make room
      end
    end else begin
      entry_d = entry_q;  // hold
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

>>> rtl/core/grouped_min_max_sum_count.sv
// ---------------------------------------------------------------------------
// grouped_min_max_sum_count
// Keyed group-by aggregation (min, max, sum, count) in a sorted cell chain.
// ---------------------------------------------------------------------------
// Each input word is either a record (tuser = 0) carrying a 16-bit key and a
// signed 32-bit score, or a flush (tuser = 1). For a record, the
// key is broadcast to a row of TABLE_DEPTH cells that hold the entries sorted
// by ascending key; the matching cell updates min/max/sum/count, or, for a new
// key, the cells above the insertion point shift up by one and the new entry
// opens with count 1. Records yield no output. A record that finds the table
// full, or its key's count at 0xFFFFFFFF, is dropped and sets a sticky drop
// flag. A flush emits one output word per entry in key order, tlast on the
// final one, then the table and drop flag clear; an empty table gives one
// word with table_empty set, tlast set and zero data. dropped_flag shows the
// drop flag as it stood at the flush. Records go at one word per cycle while
// no flush is in progress; after a flush is taken, input is held off until
// the last output word is loaded, as the chain shifts down toward cell 0 by
// one slot per output word, stalling while the output register is still
// full under back-pressure. An output register fronts the master port.
// ---------------------------------------------------------------------------
module grouped_min_max_sum_count #(
  parameter int unsigned TABLE_DEPTH = gmmsc_pkg::TableDepthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [gmmsc_pkg::InDataW-1:0]   s_axis_tdata,  // group_key[15:0], score[47:16]
  input  logic [0:0]                      s_axis_tuser,  // opcode[0]
  // master side
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [gmmsc_pkg::OutDataW-1:0]  m_axis_tdata,  // out_key[15:0], min_value[47:16],
                                                         // max_value[79:48], total[143:80],
                                                         // record_count[175:144]
  output logic                            m_axis_tlast,  // last_entry
  output logic [gmmsc_pkg::OutUserW-1:0]  m_axis_tuser   // table_empty[0], dropped_flag[1]
);
  import gmmsc_pkg::*;

  // input word unpack
  logic [KeyW-1:0]          in_key;
  logic signed [ScoreW-1:0] in_score;
  opcode_e                  in_op;
  logic                     in_fire, rec_fire;

  assign in_key   = s_axis_tdata[KeyW-1:0];
  assign in_score = s_axis_tdata[KeyW+ScoreW-1:KeyW];
  assign in_op    = opcode_e'(s_axis_tuser);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign rec_fire = in_fire && (in_op == OpRecord);

  // cell chain
  entry_t                 entries   [TABLE_DEPTH];
  entry_t                 prev_e    [TABLE_DEPTH];
  entry_t                 next_e    [TABLE_DEPTH];
  cell_stat_t             stats     [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] prev_lt;
  logic [TABLE_DEPTH-1:0] eq_vec, sat_vec;
  cell_ctl_t              ctl;

  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
    if (gi == 0) begin : g_head
      assign prev_e[gi]  = '0;
      assign prev_lt[gi] = 1'b1;  // slot 0 is the insertion point unless passed
    end else begin : g_body
      assign prev_e[gi]  = entries[gi-1];
      assign prev_lt[gi] = stats[gi-1].lt;
    end
    if (gi == TABLE_DEPTH - 1) begin : g_tail
      assign next_e[gi] = '0;     // an empty slot enters at the top on flush
    end else begin : g_mid
      assign next_e[gi] = entries[gi+1];
    end

    assign eq_vec[gi]  = stats[gi].eq;
    assign sat_vec[gi] = stats[gi].sat;

    gmmsc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .key_i        (in_key),
      .score_i      (in_score),
      .prev_lt_i    (prev_lt[gi]),
      .prev_entry_i (prev_e[gi]),
      .next_entry_i (next_e[gi]),
      .entry_o      (entries[gi]),
      .stat_o       (stats[gi])
    );
  end

  logic any_eq, any_sat, full;

  assign any_eq  = |eq_vec;
  assign any_sat = |sat_vec;
  assign full    = entries[TABLE_DEPTH-1].valid;

  // flush sequencer
  state_e state_q, state_d;
  logic   out_free, last0;
  logic   load_entry, load_empty, flush_done;
  logic   m_valid_q;

  assign out_free = !m_valid_q || m_axis_tready;
  assign last0    = !next_e[0].valid;

  always_comb begin
    state_d    = state_q;
    load_entry = 1'b0;
    load_empty = 1'b0;
    flush_done = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_fire && (in_op == OpFlush)) state_d = StFlush;
      end
      StFlush: begin
        if (out_free) begin
          if (entries[0].valid) begin
            load_entry = 1'b1;
            if (last0) begin
              flush_done = 1'b1;
              state_d    = StIdle;
            end
          end else begin
            load_empty = 1'b1;
            flush_done = 1'b1;
            state_d    = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);

  assign ctl.rec_en   = rec_fire;
  assign ctl.ins_en   = rec_fire && !any_eq && !full;
  assign ctl.shift_dn = load_entry;

  // sticky drop flag
  logic drop_q, drop_d;

  always_comb begin
    drop_d = drop_q;
    if (flush_done) begin
      drop_d = 1'b0;
    end else if (rec_fire && (any_sat || (!any_eq && full))) begin
      drop_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      drop_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      drop_q  <= drop_d;
      if (load_entry || load_empty) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // output register
  logic [OutDataW-1:0] out_data_q;
  logic                out_last_q;
  logic [OutUserW-1:0] out_user_q;

  always_ff @(posedge clk_i) begin
    if (load_entry) begin
      out_data_q <= {entries[0].count, entries[0].sum, entries[0].max_v,
                     entries[0].min_v, entries[0].key};
      out_last_q <= last0;
      out_user_q <= {drop_q, 1'b0};
    end else if (load_empty) begin
      out_data_q <= '0;
      out_last_q <= 1'b1;
      out_user_q <= {drop_q, 1'b1};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

endmodule

>>> rtl/core/gmmsc_checker.sv
// ---------------------------------------------------------------------------
// gmmsc_checker
// Port-level checks for the group-by aggregation block, bound to the top.
// ---------------------------------------------------------------------------
`include "grouped_min_max_sum_count_macros.svh"

module gmmsc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [gmmsc_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                            m_axis_tlast,
  input logic [gmmsc_pkg::OutUserW-1:0]  m_axis_tuser
);

  // stalled output word holds
  `GMMSC_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "output word changed under stall")

  // empty-table word: last, zero data
  `GMMSC_ASSERT_IMP(a_empty_word, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && (m_axis_tdata == '0), "empty flush word malformed")

  // no input taken while a flush is still mid-table
  `GMMSC_ASSERT_IMP(a_flush_blocks, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input accepted during flush")

endmodule

bind grouped_min_max_sum_count gmmsc_checker u_gmmsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
